// ----- hdl/mdst_pkg.sv -----
package mdst_pkg;

    localparam int ACC_BITS = 23;
    localparam int WIN_BITS = 10;
    localparam int SHARE_BITS = 16;
    localparam int TOT_BITS = ACC_BITS + 2;
    localparam int LANES = 4;
    localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(10);

    localparam int LANE_FWD = 0;
    localparam int LANE_BACK = 1;
    localparam int LANE_LEFT = 2;
    localparam int LANE_RIGHT = 3;

    typedef struct packed {
        logic moved;
        logic heading_left;
        logic fwd_x;
        logic right_y;
        logic clear;
    } mdst_ctl_t;

endpackage

// ----- hdl/mdst_front.sv -----
module mdst_front
    import mdst_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [WIN_BITS-1:0]        cfg_wdata,
    input  logic                       take,
    input  logic [COORD_BITS-1:0]      point_x,
    input  logic [COORD_BITS-1:0]      point_y,
    output mdst_ctl_t                  ctl,
    output logic [COORD_BITS+1:0]      next_x,
    output logic [COORD_BITS+1:0]      next_y,
    output logic [COORD_BITS-1:0]      abs_x,
    output logic [COORD_BITS-1:0]      abs_y
);

    logic [WIN_BITS-1:0]   win_len_reg;
    logic [COORD_BITS-1:0] last_x_reg;
    logic [COORD_BITS-1:0] last_y_reg;
    logic [WIN_BITS-1:0]   moves_reg;
    logic [WIN_BITS-1:0]   moves_next;
    logic [1:0]            seen_reg;
    logic                  travel_reg;
    logic                  travel_next;

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   adx;
    logic [COORD_BITS:0]   ady;
    logic                  dx_pos;
    logic                  dy_pos;
    logic                  moved;
    logic [WIN_BITS:0]     cnt_inc;
    logic [WIN_BITS-1:0]   win;
    logic                  clear;

    always_comb begin
        moved  = (last_x_reg != '0) || (last_y_reg != '0);
        dx     = {1'b0, point_x} - {1'b0, last_x_reg};
        dy     = {1'b0, point_y} - {1'b0, last_y_reg};
        adx    = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
        ady    = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
        abs_x  = adx[COORD_BITS-1:0];
        abs_y  = ady[COORD_BITS-1:0];
        next_x = {2'b00, point_x} + {dx[COORD_BITS], dx};
        next_y = {2'b00, point_y} + {dy[COORD_BITS], dy};
        dx_pos = !dx[COORD_BITS] && (dx != '0);
        dy_pos = !dy[COORD_BITS] && (dy != '0);

        travel_next = (seen_reg == 2'd1) ? !dx_pos : travel_reg;

        cnt_inc    = {1'b0, moves_reg} + 1'b1;
        win        = (win_len_reg == '0) ? WIN_BITS'(1) : win_len_reg;
        clear      = cnt_inc >= {1'b0, win};
        moves_next = clear ? '0 : cnt_inc[WIN_BITS-1:0];

        ctl.moved        = moved;
        ctl.heading_left = moved && travel_next;
        ctl.fwd_x        = travel_next ? dx[COORD_BITS] : dx_pos;
        ctl.right_y      = travel_next ? dy[COORD_BITS] : dy_pos;
        ctl.clear        = clear;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= WIN_RESET;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            moves_reg   <= '0;
            seen_reg    <= '0;
            travel_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                win_len_reg <= cfg_wdata;
            end
            if (take) begin
                last_x_reg <= point_x;
                last_y_reg <= point_y;
                if (moved) begin
                    moves_reg  <= moves_next;
                    travel_reg <= travel_next;
                    if (seen_reg != 2'd2) begin
                        seen_reg <= seen_reg + 2'd1;
                    end
                end
            end
        end
    end

endmodule

// ----- hdl/mdst_queue.sv -----
module mdst_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- hdl/mdst_back.sv -----
module mdst_back
    import mdst_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int M_DW = 96
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  mdst_ctl_t             q_ctl,
    input  logic [COORD_BITS+1:0] q_next_x,
    input  logic [COORD_BITS+1:0] q_next_y,
    input  logic [COORD_BITS-1:0] q_abs_x,
    input  logic [COORD_BITS-1:0] q_abs_y,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DW-1:0]       m_tdata,
    output logic [1:0]            m_tuser
);

    localparam int NW = COORD_BITS + 2;
    localparam int DATA_BITS = 2 * NW + 1 + LANES * SHARE_BITS;
    localparam int STEPS = SHARE_BITS;
    localparam int CNT_W = $clog2(STEPS);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ACC  = 5'b00010,
        ST_TOT  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    mdst_ctl_t               ctl_reg, ctl_next;
    logic [NW-1:0]           nx_reg, nx_next;
    logic [NW-1:0]           ny_reg, ny_next;
    logic [COORD_BITS-1:0]   ax_reg, ax_next;
    logic [COORD_BITS-1:0]   ay_reg, ay_next;
    logic [ACC_BITS-1:0]     acc_reg [LANES];
    logic [ACC_BITS-1:0]     acc_next [LANES];
    logic [TOT_BITS-1:0]     rem_reg [LANES];
    logic [TOT_BITS-1:0]     rem_next [LANES];
    logic [SHARE_BITS-1:0]   quo_reg [LANES];
    logic [SHARE_BITS-1:0]   quo_next [LANES];
    logic [TOT_BITS-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [M_DW-1:0]         out_data_reg, out_data_next;
    logic [1:0]              out_user_reg, out_user_next;

    logic [ACC_BITS-1:0]     base [LANES];
    logic [ACC_BITS-1:0]     addend [LANES];
    logic [SHARE_BITS-1:0]   share [LANES];
    logic [TOT_BITS:0]       dbl [LANES];
    logic [DATA_BITS-1:0]    packed_data;
    logic                    tot_nz;

    function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                    input logic [ACC_BITS-1:0] b);
        logic [ACC_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_BITS] ? {ACC_BITS{1'b1}} : s[ACC_BITS-1:0];
    endfunction

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        state_next     = state_reg;
        ctl_next       = ctl_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        total_next     = total_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_valid_next = out_valid_reg && !m_tready;
        q_pop          = 1'b0;
        tot_nz         = (total_reg != '0);

        for (int i = 0; i < LANES; i++) begin
            acc_next[i] = acc_reg[i];
            rem_next[i] = rem_reg[i];
            quo_next[i] = quo_reg[i];
            base[i]     = ctl_reg.clear ? '0 : acc_reg[i];
            addend[i]   = '0;
            dbl[i]      = {rem_reg[i], 1'b0};
            if (!ctl_reg.moved || !tot_nz) begin
                share[i] = '0;
            end else if ({2'b00, acc_reg[i]} == total_reg) begin
                share[i] = '1;
            end else begin
                share[i] = quo_reg[i];
            end
        end

        if (ctl_reg.fwd_x) begin
            addend[LANE_FWD] = ACC_BITS'(ax_reg);
        end else begin
            addend[LANE_BACK] = ACC_BITS'(ax_reg);
        end
        if (ctl_reg.right_y) begin
            addend[LANE_RIGHT] = ACC_BITS'(ay_reg);
        end else begin
            addend[LANE_LEFT] = ACC_BITS'(ay_reg);
        end

        packed_data = {share[LANE_RIGHT], share[LANE_LEFT], share[LANE_BACK],
                       share[LANE_FWD], ctl_reg.heading_left,
                       ctl_reg.moved ? ny_reg : NW'(0),
                       ctl_reg.moved ? nx_reg : NW'(0)};

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    ctl_next   = q_ctl;
                    nx_next    = q_next_x;
                    ny_next    = q_next_y;
                    ax_next    = q_abs_x;
                    ay_next    = q_abs_y;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (ctl_reg.moved) begin
                    for (int i = 0; i < LANES; i++) begin
                        acc_next[i] = sat_add(base[i], addend[i]);
                    end
                end
                state_next = ST_TOT;
            end
            ST_TOT: begin
                total_next = {2'b00, acc_reg[LANE_FWD]} + {2'b00, acc_reg[LANE_BACK]}
                           + {2'b00, acc_reg[LANE_LEFT]} + {2'b00, acc_reg[LANE_RIGHT]};
                for (int i = 0; i < LANES; i++) begin
                    rem_next[i] = {2'b00, acc_reg[i]};
                    quo_next[i] = '0;
                end
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                for (int i = 0; i < LANES; i++) begin
                    if (dbl[i] >= {1'b0, total_reg}) begin
                        rem_next[i] = TOT_BITS'(dbl[i] - {1'b0, total_reg});
                        quo_next[i] = {quo_reg[i][SHARE_BITS-2:0], 1'b1};
                    end else begin
                        rem_next[i] = dbl[i][TOT_BITS-1:0];
                        quo_next[i] = {quo_reg[i][SHARE_BITS-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = M_DW'(packed_data);
                    out_user_next  = {ctl_reg.moved && tot_nz, ctl_reg.moved};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        ctl_reg      <= ctl_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        total_reg    <= total_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        for (int i = 0; i < LANES; i++) begin
            rem_reg[i] <= rem_next[i];
            quo_reg[i] <= quo_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < LANES; i++) begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

endmodule

// ----- hdl/motion_direction_share_tracker_core.sv -----
// tracks one object's center point and reports the predicted next point and
// the forward, back, left and right shares of recent travel as Q0.16
// fractions. each point goes through these steps in order: a fetch from the
// input queue, an update of the saturating direction accumulators, a sum of
// them, the four share dividers running side by side at one quotient bit
// per cycle, and a load of the output register. the input side holds the
// previous point and window count itself and can run up to two points
// ahead of the divider through a two-entry queue; the back end takes the
// next point only after the last result is loaded for output. window_length
// is written through cfg_we/cfg_wdata and should only change while the
// block is idle; zero behaves as one. a previous point of (0,0) yields an
// all-zero result with moved low.
module motion_direction_share_tracker_core
    import mdst_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [WIN_BITS-1:0]  cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // point_x, point_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // next_x, next_y, heading_left, share_forward, share_back, share_left,
    // share_right
    output logic [((2*(COORD_BITS+2)+1+4*SHARE_BITS+7)/8)*8-1:0] m_tdata,
    // moved, shares_valid
    output logic [1:0]           m_tuser
);

    localparam int NW = COORD_BITS + 2;
    localparam int M_DW = ((2 * NW + 1 + LANES * SHARE_BITS + 7) / 8) * 8;
    localparam int CTL_W = $bits(mdst_ctl_t);
    localparam int Q_W = CTL_W + 2 * NW + 2 * COORD_BITS;

    mdst_ctl_t             f_ctl;
    logic [NW-1:0]         f_next_x;
    logic [NW-1:0]         f_next_y;
    logic [COORD_BITS-1:0] f_abs_x;
    logic [COORD_BITS-1:0] f_abs_y;
    logic                  take;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic [Q_W-1:0]        q_in;
    logic [Q_W-1:0]        q_out;
    mdst_ctl_t             b_ctl;

    assign s_tready = !q_full;
    assign take     = s_tvalid && !q_full;
    assign q_in     = {f_ctl, f_next_x, f_next_y, f_abs_x, f_abs_y};
    assign b_ctl    = q_out[Q_W-1 -: CTL_W];

    mdst_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .take     (take),
        .point_x  (s_tdata[COORD_BITS-1:0]),
        .point_y  (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .ctl      (f_ctl),
        .next_x   (f_next_x),
        .next_y   (f_next_y),
        .abs_x    (f_abs_x),
        .abs_y    (f_abs_y)
    );

    mdst_queue #(
        .WIDTH(Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (take),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_valid),
        .pop_data (q_out)
    );

    mdst_back #(
        .COORD_BITS(COORD_BITS),
        .M_DW      (M_DW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_ctl    (b_ctl),
        .q_next_x (q_out[2*COORD_BITS+2*NW-1 -: NW]),
        .q_next_y (q_out[2*COORD_BITS+NW-1 -: NW]),
        .q_abs_x  (q_out[2*COORD_BITS-1 -: COORD_BITS]),
        .q_abs_y  (q_out[COORD_BITS-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- tb/tb_top.sv -----
module tb_top
    import mdst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 12;
    localparam int NEXT_BITS = COORD_BITS + 2;
    localparam int IN_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((2 * NEXT_BITS + 1 + 4 * SHARE_BITS + 7) / 8) * 8;
    localparam int HL_BIT = 2 * NEXT_BITS;
    localparam int SH_LSB = HL_BIT + 1;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam int ACC_MAX = (1 << ACC_BITS) - 1;
    localparam int SHARE_MAX = (1 << SHARE_BITS) - 1;
    localparam int PHASES = 5;
    localparam int PHASE_POINTS = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic {
        ROW_POINT,
        ROW_WINDOW
    } row_kind_t;

    typedef struct packed {
        logic                  moved;
        logic [NEXT_BITS-1:0]  next_x;
        logic [NEXT_BITS-1:0]  next_y;
        logic                  heading_left;
        logic [SHARE_BITS-1:0] share_fwd;
        logic [SHARE_BITS-1:0] share_back;
        logic [SHARE_BITS-1:0] share_left;
        logic [SHARE_BITS-1:0] share_right;
        logic                  shares_valid;
    } track_report_t;

    typedef struct {
        row_kind_t       kind;
        int              x;
        int              y;
        logic [WIN_BITS-1:0] win;
        bit              typed;
        track_report_t   report;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [WIN_BITS-1:0] cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // point_x, point_y
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // next_x, next_y, heading_left, share_forward, share_back, share_left, share_right
    logic [OUT_W-1:0]    m_tdata;
    // moved, shares_valid
    logic [1:0]          m_tuser;

    // tracker state mirrored by the predictor
    int window_len = WIN_RESET;
    int last_x = 0;
    int last_y = 0;
    int moves_in_window = 0;
    int moves_seen = 0;
    bit travel_left = 1'b0;
    int acc_fwd = 0;
    int acc_back = 0;
    int acc_left = 0;
    int acc_right = 0;

    track_report_t predicted_reports[$];
    bit            point_typed = 1'b0;
    track_report_t point_typed_report = '0;
    bit            idling_on = 1'b1;
    bit            tx_calm = 1'b0;
    bit            hold_request = 1'b0;

    int errors = 0;
    int points_accepted = 0;
    int moves_total = 0;
    int sentinel_reports = 0;
    int zero_total_reports = 0;
    int window_writes = 0;
    int stall_cycles = 0;

    motion_direction_share_tracker_core #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic track_report_t make_report(bit moved, int nx, int ny, bit hl,
                                                  int f, int b, int l, int r, bit v);
        track_report_t rep;
        rep.moved = moved;
        rep.next_x = NEXT_BITS'(nx);
        rep.next_y = NEXT_BITS'(ny);
        rep.heading_left = hl;
        rep.share_fwd = SHARE_BITS'(f);
        rep.share_back = SHARE_BITS'(b);
        rep.share_left = SHARE_BITS'(l);
        rep.share_right = SHARE_BITS'(r);
        rep.shares_valid = v;
        return rep;
    endfunction

    function automatic stim_row_t point_row(int x, int y);
        stim_row_t row;
        row.kind = ROW_POINT;
        row.x = x;
        row.y = y;
        row.win = '0;
        row.typed = 1'b0;
        row.report = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(int x, int y, track_report_t rep);
        stim_row_t row;
        row = point_row(x, y);
        row.typed = 1'b1;
        row.report = rep;
        return row;
    endfunction

    function automatic stim_row_t window_row(int v);
        stim_row_t row;
        row = point_row(0, 0);
        row.kind = ROW_WINDOW;
        row.win = WIN_BITS'(v);
        return row;
    endfunction

    function automatic int sat_acc(int acc, int v);
        return (acc + v > ACC_MAX) ? ACC_MAX : acc + v;
    endfunction

    function automatic logic [SHARE_BITS-1:0] share_of_total(int a, longint total);
        longint q;
        if (total == 0) return '0;
        q = (longint'(a) << SHARE_BITS) / total;
        return (q > SHARE_MAX) ? SHARE_BITS'(SHARE_MAX) : SHARE_BITS'(q);
    endfunction

    function automatic track_report_t predict_motion(int px, int py);
        track_report_t rep;
        int dx, dy, ax, ay, win;
        bit fwd_x, right_y;
        longint total;
        rep = '0;
        if (last_x != 0 || last_y != 0) begin
            dx = px - last_x;
            dy = py - last_y;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            win = (window_len == 0) ? 1 : window_len;
            if (moves_seen == 1) travel_left = (dx > 0) ? 1'b0 : 1'b1;
            if (moves_seen < 2) moves_seen++;
            moves_in_window++;
            if (moves_in_window >= win) begin
                moves_in_window = 0;
                acc_fwd = 0;
                acc_back = 0;
                acc_left = 0;
                acc_right = 0;
            end
            if (!travel_left) begin
                fwd_x = dx > 0;
                right_y = dy > 0;
            end else begin
                fwd_x = dx < 0;
                right_y = dy < 0;
            end
            if (fwd_x) acc_fwd = sat_acc(acc_fwd, ax);
            else acc_back = sat_acc(acc_back, ax);
            if (right_y) acc_right = sat_acc(acc_right, ay);
            else acc_left = sat_acc(acc_left, ay);
            total = longint'(acc_fwd) + acc_back + acc_left + acc_right;
            rep.moved = 1'b1;
            rep.next_x = NEXT_BITS'(px + dx);
            rep.next_y = NEXT_BITS'(py + dy);
            rep.heading_left = travel_left;
            rep.share_fwd = share_of_total(acc_fwd, total);
            rep.share_back = share_of_total(acc_back, total);
            rep.share_left = share_of_total(acc_left, total);
            rep.share_right = share_of_total(acc_right, total);
            rep.shares_valid = total != 0;
        end
        last_x = px;
        last_y = py;
        return rep;
    endfunction

    function automatic string report_text(track_report_t r);
        return $sformatf("moved=%0d next=(%0d,%0d) left=%0d shares=%0d/%0d/%0d/%0d valid=%0d",
                         r.moved, $signed(r.next_x), $signed(r.next_y), r.heading_left,
                         r.share_fwd, r.share_back, r.share_left, r.share_right,
                         r.shares_valid);
    endfunction

    task automatic send_point(int x, int y, bit typed, track_report_t rep);
        s_tdata <= IN_W'({COORD_BITS'(y), COORD_BITS'(x)});
        s_tvalid <= 1'b1;
        point_typed = typed;
        point_typed_report = rep;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (idling_on && !tx_calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    endtask

    task automatic write_window(logic [WIN_BITS-1:0] v);
        s_tvalid <= 1'b0;
        while (predicted_reports.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        window_len = v;
        window_writes++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // scoreboard and watchdog
    always @(posedge aclk) begin
        track_report_t want, got;
        bit moved_any;
        if (aresetn) begin
            moved_any = 1'b0;
            if (s_tvalid && s_tready) begin
                want = predict_motion(int'(s_tdata[COORD_BITS-1:0]),
                                      int'(s_tdata[2*COORD_BITS-1:COORD_BITS]));
                if (point_typed) want = point_typed_report;
                predicted_reports = {predicted_reports, want};
                points_accepted++;
                if (want.moved) moves_total++;
                else sentinel_reports++;
                if (want.moved && !want.shares_valid) zero_total_reports++;
                moved_any = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                got.moved = m_tuser[0];
                got.shares_valid = m_tuser[1];
                got.next_x = m_tdata[NEXT_BITS-1:0];
                got.next_y = m_tdata[2*NEXT_BITS-1:NEXT_BITS];
                got.heading_left = m_tdata[HL_BIT];
                got.share_fwd = m_tdata[SH_LSB +: SHARE_BITS];
                got.share_back = m_tdata[SH_LSB + SHARE_BITS +: SHARE_BITS];
                got.share_left = m_tdata[SH_LSB + 2*SHARE_BITS +: SHARE_BITS];
                got.share_right = m_tdata[SH_LSB + 3*SHARE_BITS +: SHARE_BITS];
                if (predicted_reports.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("unexpected result: %s", report_text(got));
                end else begin
                    want = predicted_reports.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= REPORT_LIMIT) begin
                            $display("mismatch expected: %s", report_text(want));
                            $display("         actual:   %s", report_text(got));
                        end
                    end
                end
                moved_any = 1'b1;
            end
            if (moved_any) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= WATCHDOG_CYCLES) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         stall_cycles, predicted_reports.size());
                $display("** motion_direction_share_tracker_core: FAILED **");
                $finish;
            end
        end
    end

    // result side: random back-pressure with calm stretches and one long hold
    initial begin
        int gap;
        int stretch;
        bit calm;
        stretch = 0;
        calm = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (idling_on && !calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
            if (stretch == 0) begin
                calm = $urandom_range(0, 2) == 0;
                stretch = $urandom_range(50, 200);
            end else begin
                stretch--;
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        int mode, px, py, track_x, track_y, win;
        rows = {rows, typed_row(100, 200, make_report(0, 0, 0, 0, 0, 0, 0, 0, 0))};
        rows = {rows, typed_row(100, 200, make_report(1, 100, 200, 0, 0, 0, 0, 0, 0))};
        rows = {rows, typed_row(50, 200, make_report(1, 0, 200, 1, SHARE_MAX, 0, 0, 0, 1))};
        rows = {rows, point_row(COORD_MAX, COORD_MAX)};
        rows = {rows, point_row(0, COORD_MAX)};
        rows = {rows, point_row(0, 0)};
        rows = {rows, typed_row(COORD_MAX, 0, make_report(0, 0, 0, 0, 0, 0, 0, 0, 0))};
        rows = {rows, point_row(0, COORD_MAX)};
        rows = {rows, point_row(COORD_MAX, 0)};
        rows = {rows, point_row(COORD_MAX, 0)};
        rows = {rows, point_row(2048, 2048)};
        rows = {rows, point_row(2047, 2049)};
        rows = {rows, window_row(1)};
        rows = {rows, typed_row(2047, 2054,
                                make_report(1, 2047, 2059, 1, 0, 0, SHARE_MAX, 0, 1))};
        rows = {rows, typed_row(2047, 2054, make_report(1, 2047, 2054, 1, 0, 0, 0, 0, 0))};
        rows = {rows, window_row(0)};
        rows = {rows, typed_row(2040, 2054,
                                make_report(1, 2033, 2054, 1, SHARE_MAX, 0, 0, 0, 1))};
        rows = {rows, typed_row(2040, 2050,
                                make_report(1, 2040, 2046, 1, 0, 0, 0, SHARE_MAX, 1))};
        rows = {rows, typed_row(2050, 2050,
                                make_report(1, 2060, 2050, 1, 0, SHARE_MAX, 0, 0, 1))};
        rows = {rows, window_row((1 << WIN_BITS) - 1)};
        rows = {rows, point_row(1, 1)};
        rows = {rows, point_row(COORD_MAX, COORD_MAX)};
        rows = {rows, point_row(COORD_MAX - 1, 1)};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_WINDOW) write_window(rows[i].win);
            else send_point(rows[i].x, rows[i].y, rows[i].typed, rows[i].report);
        end

        track_x = COORD_MAX - 1;
        track_y = 1;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: win = (1 << WIN_BITS) - 1;
                1: win = $urandom_range(2, 40);
                2: win = 1;
                3: win = $urandom_range(0, (1 << WIN_BITS) - 1);
                default: win = $urandom_range(3, 16);
            endcase
            write_window(WIN_BITS'(win));
            if (p == 1) hold_request = 1'b1;
            if (p == PHASES - 1) idling_on = 1'b0;
            for (int i = 0; i < PHASE_POINTS; i++) begin
                if (i % 50 == 0) tx_calm = $urandom_range(0, 2) == 0;
                mode = $urandom_range(0, 99);
                if (mode < 60) begin
                    px = track_x + $urandom_range(0, 80) - 40;
                    py = track_y + $urandom_range(0, 80) - 40;
                end else if (mode < 75) begin
                    px = $urandom_range(0, COORD_MAX);
                    py = $urandom_range(0, COORD_MAX);
                end else if (mode < 85) begin
                    case ($urandom_range(0, 4))
                        0: px = 0;
                        1: px = COORD_MAX;
                        2: px = 1;
                        3: px = COORD_MAX - 1;
                        default: px = $urandom_range(0, COORD_MAX);
                    endcase
                    case ($urandom_range(0, 4))
                        0: py = 0;
                        1: py = COORD_MAX;
                        2: py = 1;
                        3: py = COORD_MAX - 1;
                        default: py = $urandom_range(0, COORD_MAX);
                    endcase
                end else if (mode < 90) begin
                    px = track_x;
                    py = track_y;
                end else if (mode < 95) begin
                    px = 0;
                    py = 0;
                end else if (mode < 97) begin
                    px = $urandom_range(0, COORD_MAX);
                    py = track_y;
                end else begin
                    px = track_x;
                    py = $urandom_range(0, COORD_MAX);
                end
                px = (px < 0) ? 0 : (px > COORD_MAX) ? COORD_MAX : px;
                py = (py < 0) ? 0 : (py > COORD_MAX) ? COORD_MAX : py;
                // keep tracks from sticking to the origin
                if (px == 0 && py == 0 && mode < 90) px = 1;
                track_x = px;
                track_y = py;
                send_point(px, py, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (predicted_reports.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("run covered %0d points: %0d movements, %0d origin results, %0d zero-total",
                 points_accepted, moves_total, sentinel_reports, zero_total_reports);
        $display("%0d window lengths written, one %0d-cycle result hold-off, %0d mismatches",
                 window_writes, HOLD_CYCLES, errors);
        if (errors == 0) begin
            $display("** motion_direction_share_tracker_core: PASSED **");
        end else begin
            $display("** motion_direction_share_tracker_core: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/mdst_pkg.sv
hdl/mdst_front.sv
hdl/mdst_queue.sv
hdl/mdst_back.sv
hdl/motion_direction_share_tracker_core.sv
tb/tb_top.sv
